@@ src/pmfaw_pkg.sv @@
// ----------------------------------------------------------------------------
// pmfaw_pkg
// Shared codes, types and helpers for the packed matrix fill address walker.
// ----------------------------------------------------------------------------
package pmfaw_pkg;

   // default matrix dimension limit
   localparam int unsigned MAX_NODES_DEFAULT = 1024;

   // fixed field widths
   localparam int unsigned WEIGHT_W     = 32;
   localparam int unsigned INDEX_OUT_W  = 10;
   localparam int unsigned LAYOUT_W     = 4;
   localparam int unsigned NODE_COUNT_W = 11;
   localparam int unsigned CSR_DATA_W   = 11;
   localparam int unsigned CSR_INDEX_W  = 4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LAYOUT     = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_COUNT = 4'd1;

   // layout codes
   localparam logic [LAYOUT_W-1:0] LAYOUT_FULL           = 4'd0;
   localparam logic [LAYOUT_W-1:0] LAYOUT_UPPER_ROW      = 4'd1;
   localparam logic [LAYOUT_W-1:0] LAYOUT_LOWER_ROW      = 4'd2;
   localparam logic [LAYOUT_W-1:0] LAYOUT_UPPER_DIAG_ROW = 4'd3;
   localparam logic [LAYOUT_W-1:0] LAYOUT_LOWER_DIAG_ROW = 4'd4;
   localparam logic [LAYOUT_W-1:0] LAYOUT_UPPER_COL      = 4'd5;
   localparam logic [LAYOUT_W-1:0] LAYOUT_LOWER_COL      = 4'd6;
   localparam logic [LAYOUT_W-1:0] LAYOUT_UPPER_DIAG_COL = 4'd7;
   localparam logic [LAYOUT_W-1:0] LAYOUT_LOWER_DIAG_COL = 4'd8;

   // status of one walk step
   typedef struct packed {
      logic has_result;
      logic mirror;
      logic last;
   } walk_status_type;

   // strict upper layouts start one column right of the diagonal
   function automatic logic start_col_one(input logic [LAYOUT_W-1:0] layout);
      start_col_one = (layout == LAYOUT_UPPER_ROW) || (layout == LAYOUT_UPPER_COL);
   endfunction

   // strict lower layouts start one row below the diagonal
   function automatic logic start_row_one(input logic [LAYOUT_W-1:0] layout);
      start_row_one = (layout == LAYOUT_LOWER_ROW) || (layout == LAYOUT_LOWER_COL);
   endfunction

endpackage

@@ src/packed_matrix_fill_address_walker_core.sv @@
// ----------------------------------------------------------------------------
// packed_matrix_fill_address_walker_core
// Tags a stream of packed square-matrix weights with their row and column.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  req     | in        | req_valid/req_stall | req_weight
//  rsp     | out       | rsp_valid/rsp_stall | rsp_weight_out, rsp_row_index,
//          |           |                     | rsp_col_index, rsp_mirror_write,
//          |           |                     | rsp_last_entry
//  csr     | in        | csr_write_enable    | csr_index, csr_write_data
//
// one weight per cycle while rsp is not stalled; each result appears in the cycle
// after its transfer, from the result register.
// reset is synchronous and leaves layout full, one node, walk at (0,0).
// req_stall rises only while a held result is stalled on rsp.
// a csr write to layout or node count restarts the walk at the layout's start position.
// ----------------------------------------------------------------------------
module packed_matrix_fill_address_walker_core #(
   parameter int unsigned MAX_NODES = pmfaw_pkg::MAX_NODES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [pmfaw_pkg::WEIGHT_W-1:0] req_weight,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [pmfaw_pkg::WEIGHT_W-1:0] rsp_weight_out,
   output logic [pmfaw_pkg::INDEX_OUT_W-1:0]     rsp_row_index,
   output logic [pmfaw_pkg::INDEX_OUT_W-1:0]     rsp_col_index,
   output logic                                  rsp_mirror_write,
   output logic                                  rsp_last_entry,
   // configuration port
   input  logic                                  csr_write_enable,
   input  logic [pmfaw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pmfaw_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int unsigned IDX_W   = $clog2(MAX_NODES + 1);
   localparam int unsigned CLAMP_W = (IDX_W > pmfaw_pkg::NODE_COUNT_W) ?
                                     IDX_W : pmfaw_pkg::NODE_COUNT_W;
   localparam int unsigned WIDE_W  = IDX_W + pmfaw_pkg::INDEX_OUT_W;

   // configuration registers
   logic [pmfaw_pkg::LAYOUT_W-1:0] layout_ff, layout_in;
   logic [IDX_W-1:0]               node_count_ff, node_count_in;
   // walk position
   logic [IDX_W-1:0]               walk_row_ff, walk_row_in;
   logic [IDX_W-1:0]               walk_col_ff, walk_col_in;
   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pmfaw_pkg::WEIGHT_W-1:0] weight_ff, weight_in;
   logic [pmfaw_pkg::INDEX_OUT_W-1:0] row_ff, row_in;
   logic [pmfaw_pkg::INDEX_OUT_W-1:0] col_ff, col_in;
   logic                           mirror_ff, mirror_in;
   logic                           last_ff, last_in;

   logic [IDX_W-1:0]               step_row;
   logic [IDX_W-1:0]               step_col;
   pmfaw_pkg::walk_status_type     step_status;
   logic                           out_ready;
   logic                           req_xfer;
   logic [CLAMP_W-1:0]             wr_count;
   logic [IDX_W-1:0]               wr_count_clamped;
   logic [pmfaw_pkg::LAYOUT_W-1:0] restart_layout;
   logic                           csr_hit;
   logic [WIDE_W-1:0]              row_wide;
   logic [WIDE_W-1:0]              col_wide;

   pmfaw_walk_step #(
      .IDX_W(IDX_W)
   ) u_step (
      .layout     (layout_ff),
      .node_count (node_count_ff),
      .walk_row   (walk_row_ff),
      .walk_col   (walk_col_ff),
      .next_row   (step_row),
      .next_col   (step_col),
      .status     (step_status)
   );

   // handshake: result register frees when empty or being drained
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !out_ready;
   assign req_xfer  = req_valid && out_ready;

   // node count clamped to 1..MAX_NODES at write time
   assign wr_count = CLAMP_W'(csr_write_data);
   always_comb begin
      if (wr_count == '0) begin
         wr_count_clamped = IDX_W'(1);
      end else if (wr_count > CLAMP_W'(MAX_NODES)) begin
         wr_count_clamped = IDX_W'(MAX_NODES);
      end else begin
         wr_count_clamped = IDX_W'(wr_count);
      end
   end

   // configuration write decode
   always_comb begin
      layout_in     = layout_ff;
      node_count_in = node_count_ff;
      csr_hit       = 1'b0;
      if (csr_write_enable) begin
         case (csr_index)
            pmfaw_pkg::CSR_LAYOUT: begin
               layout_in = csr_write_data[pmfaw_pkg::LAYOUT_W-1:0];
               csr_hit   = 1'b1;
            end
            pmfaw_pkg::CSR_NODE_COUNT: begin
               node_count_in = wr_count_clamped;
               csr_hit       = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   // walk position: restart on config or after the last entry
   assign restart_layout = layout_in;
   always_comb begin
      walk_row_in = walk_row_ff;
      walk_col_in = walk_col_ff;
      if (csr_hit || (req_xfer && step_status.has_result && step_status.last)) begin
         walk_row_in = IDX_W'(pmfaw_pkg::start_row_one(restart_layout));
         walk_col_in = IDX_W'(pmfaw_pkg::start_col_one(restart_layout));
      end else if (req_xfer && step_status.has_result) begin
         walk_row_in = step_row;
         walk_col_in = step_col;
      end
   end

   // output indexes keep the low ten bits
   assign row_wide = WIDE_W'(walk_row_ff);
   assign col_wide = WIDE_W'(walk_col_ff);

   // result register load
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      weight_in    = weight_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      mirror_in    = mirror_ff;
      last_in      = last_ff;
      if (out_ready) begin
         rsp_valid_in = req_xfer && step_status.has_result;
         if (req_xfer) begin
            weight_in = req_weight;
            row_in    = row_wide[pmfaw_pkg::INDEX_OUT_W-1:0];
            col_in    = col_wide[pmfaw_pkg::INDEX_OUT_W-1:0];
            mirror_in = step_status.mirror;
            last_in   = step_status.last;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff     <= pmfaw_pkg::LAYOUT_FULL;
         node_count_ff <= IDX_W'(1);
         walk_row_ff   <= '0;
         walk_col_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         layout_ff     <= layout_in;
         node_count_ff <= node_count_in;
         walk_row_ff   <= walk_row_in;
         walk_col_ff   <= walk_col_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      weight_ff <= weight_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      mirror_ff <= mirror_in;
      last_ff   <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_weight_out   = weight_ff;
   assign rsp_row_index    = row_ff;
   assign rsp_col_index    = col_ff;
   assign rsp_mirror_write = mirror_ff;
   assign rsp_last_entry   = last_ff;

endmodule

@@ src/pmfaw_walk_step.sv @@
// ----------------------------------------------------------------------------
// pmfaw_walk_step
// Next position, last-entry detect and result qualification for one weight.
// ----------------------------------------------------------------------------
module pmfaw_walk_step #(
   parameter int unsigned IDX_W = 11
) (
   input  logic [pmfaw_pkg::LAYOUT_W-1:0] layout,
   input  logic [IDX_W-1:0]               node_count,
   input  logic [IDX_W-1:0]               walk_row,
   input  logic [IDX_W-1:0]               walk_col,
   output logic [IDX_W-1:0]               next_row,
   output logic [IDX_W-1:0]               next_col,
   output pmfaw_pkg::walk_status_type     status
);

   logic [IDX_W-1:0] n_m1;
   logic [IDX_W-1:0] n_m2;
   logic [IDX_W-1:0] row_p1;
   logic [IDX_W-1:0] col_p1;
   logic             row_end;
   logic             col_end;
   logic             diag_last;
   logic             strict;

   assign n_m1    = node_count - IDX_W'(1);
   assign n_m2    = node_count - IDX_W'(2);
   assign row_p1  = walk_row + IDX_W'(1);
   assign col_p1  = walk_col + IDX_W'(1);
   assign row_end = (walk_row == n_m1);
   assign col_end = (walk_col == n_m1);
   // bottom-right corner closes every layout that keeps the diagonal
   assign diag_last = row_end && col_end;

   assign strict = (layout == pmfaw_pkg::LAYOUT_UPPER_ROW) ||
                   (layout == pmfaw_pkg::LAYOUT_LOWER_ROW) ||
                   (layout == pmfaw_pkg::LAYOUT_UPPER_COL) ||
                   (layout == pmfaw_pkg::LAYOUT_LOWER_COL);

   // position advance and end-of-matrix detect per layout
   always_comb begin
      next_row          = walk_row;
      next_col          = walk_col;
      status.last       = 1'b0;
      status.mirror     = (layout != pmfaw_pkg::LAYOUT_FULL);
      status.has_result = 1'b1;
      case (layout)
         pmfaw_pkg::LAYOUT_FULL: begin
            status.last = diag_last;
            if (col_end) begin
               next_row = row_p1;
               next_col = '0;
            end else begin
               next_col = col_p1;
            end
         end
         pmfaw_pkg::LAYOUT_UPPER_ROW: begin
            status.last = (walk_row == n_m2) && col_end;
            if (col_end) begin
               next_row = row_p1;
               next_col = row_p1 + IDX_W'(1);
            end else begin
               next_col = col_p1;
            end
         end
         pmfaw_pkg::LAYOUT_LOWER_ROW: begin
            status.last = row_end && (walk_col == n_m2);
            if (col_p1 == walk_row) begin
               next_row = row_p1;
               next_col = '0;
            end else begin
               next_col = col_p1;
            end
         end
         pmfaw_pkg::LAYOUT_UPPER_DIAG_ROW: begin
            status.last = diag_last;
            if (col_end) begin
               next_row = row_p1;
               next_col = row_p1;
            end else begin
               next_col = col_p1;
            end
         end
         pmfaw_pkg::LAYOUT_LOWER_DIAG_ROW: begin
            status.last = diag_last;
            if (walk_col == walk_row) begin
               next_row = row_p1;
               next_col = '0;
            end else begin
               next_col = col_p1;
            end
         end
         pmfaw_pkg::LAYOUT_UPPER_COL: begin
            status.last = col_end && (walk_row == n_m2);
            if (row_p1 == walk_col) begin
               next_col = col_p1;
               next_row = '0;
            end else begin
               next_row = row_p1;
            end
         end
         pmfaw_pkg::LAYOUT_LOWER_COL: begin
            status.last = (walk_col == n_m2) && row_end;
            if (row_end) begin
               next_col = col_p1;
               next_row = col_p1 + IDX_W'(1);
            end else begin
               next_row = row_p1;
            end
         end
         pmfaw_pkg::LAYOUT_UPPER_DIAG_COL: begin
            status.last = diag_last;
            if (walk_row == walk_col) begin
               next_col = col_p1;
               next_row = '0;
            end else begin
               next_row = row_p1;
            end
         end
         pmfaw_pkg::LAYOUT_LOWER_DIAG_COL: begin
            status.last = diag_last;
            if (row_end) begin
               next_col = col_p1;
               next_row = col_p1;
            end else begin
               next_row = row_p1;
            end
         end
         default: begin
            // unknown layout: weight is dropped
            status.has_result = 1'b0;
         end
      endcase
      // a strict triangle of a one-node matrix is empty
      if (strict && (node_count == IDX_W'(1))) begin
         status.has_result = 1'b0;
      end
   end

endmodule

@@ dv/pmfaw_tag_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmfaw_tag_checker
// Watches the weight and tag channels of the address walker, keeps its own
// copy of the layout walk and compares every tag against the predicted cell.
// ----------------------------------------------------------------------------
module pmfaw_tag_checker #(
   parameter int unsigned MAX_NODES = pmfaw_pkg::MAX_NODES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic signed [pmfaw_pkg::WEIGHT_W-1:0] req_weight,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic signed [pmfaw_pkg::WEIGHT_W-1:0] rsp_weight_out,
   input  logic [pmfaw_pkg::INDEX_OUT_W-1:0]     rsp_row_index,
   input  logic [pmfaw_pkg::INDEX_OUT_W-1:0]     rsp_col_index,
   input  logic                                  rsp_mirror_write,
   input  logic                                  rsp_last_entry,
   input  logic                                  csr_write_enable,
   input  logic [pmfaw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pmfaw_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output int                                    fail_count,
   output int                                    tags_pending,
   output int                                    tags_checked,
   output int                                    matrices_closed,
   output int                                    weights_dropped
);

   localparam int unsigned NODES_W = pmfaw_pkg::NODE_COUNT_W;

   // one predicted tag: where a weight lands in the matrix
   typedef struct packed {
      logic signed [pmfaw_pkg::WEIGHT_W-1:0] weight;
      logic [pmfaw_pkg::INDEX_OUT_W-1:0]     row;
      logic [pmfaw_pkg::INDEX_OUT_W-1:0]     col;
      logic                                  mirror;
      logic                                  last;
   } cell_tag_type;

   logic [pmfaw_pkg::LAYOUT_W-1:0] cfg_layout;
   logic [NODES_W-1:0]             cfg_nodes;
   int unsigned                    walk_row;
   int unsigned                    walk_col;
   int unsigned                    cells_filled;
   cell_tag_type                   expected_tags[$];

   // matrix dimension after clamping to the supported range
   function automatic int unsigned clamped_nodes();
      if (cfg_nodes == '0) return 1;
      if (cfg_nodes > MAX_NODES) return MAX_NODES;
      return 32'(cfg_nodes);
   endfunction

   // number of stored cells for the current layout, zero if nothing is stored
   function automatic int unsigned cells_in_matrix(input int unsigned n);
      case (cfg_layout)
         pmfaw_pkg::LAYOUT_FULL: return n * n;
         pmfaw_pkg::LAYOUT_UPPER_ROW, pmfaw_pkg::LAYOUT_LOWER_ROW,
         pmfaw_pkg::LAYOUT_UPPER_COL, pmfaw_pkg::LAYOUT_LOWER_COL: return (n * n - n) / 2;
         pmfaw_pkg::LAYOUT_UPPER_DIAG_ROW, pmfaw_pkg::LAYOUT_LOWER_DIAG_ROW,
         pmfaw_pkg::LAYOUT_UPPER_DIAG_COL,
         pmfaw_pkg::LAYOUT_LOWER_DIAG_COL: return (n * n + n) / 2;
         default: return 0;
      endcase
   endfunction

   // walk start: strict triangles begin just off the diagonal
   task automatic restart_walk();
      walk_row     = 0;
      walk_col     = 0;
      cells_filled = 0;
      if (cfg_layout == pmfaw_pkg::LAYOUT_UPPER_ROW ||
          cfg_layout == pmfaw_pkg::LAYOUT_UPPER_COL) walk_col = 1;
      if (cfg_layout == pmfaw_pkg::LAYOUT_LOWER_ROW ||
          cfg_layout == pmfaw_pkg::LAYOUT_LOWER_COL) walk_row = 1;
   endtask

   // step to the next cell in the layout's order
   task automatic advance_walk(input int unsigned n);
      int unsigned r;
      int unsigned c;
      r = walk_row;
      c = walk_col;
      case (cfg_layout)
         pmfaw_pkg::LAYOUT_FULL: begin
            c++;
            if (c == n) begin r++; c = 0; end
         end
         pmfaw_pkg::LAYOUT_UPPER_ROW: begin
            c++;
            if (c == n) begin r++; c = r + 1; end
         end
         pmfaw_pkg::LAYOUT_LOWER_ROW: begin
            c++;
            if (c == r) begin r++; c = 0; end
         end
         pmfaw_pkg::LAYOUT_UPPER_DIAG_ROW: begin
            c++;
            if (c == n) begin r++; c = r; end
         end
         pmfaw_pkg::LAYOUT_LOWER_DIAG_ROW: begin
            c++;
            if (c > r) begin r++; c = 0; end
         end
         pmfaw_pkg::LAYOUT_UPPER_COL: begin
            r++;
            if (r == c) begin c++; r = 0; end
         end
         pmfaw_pkg::LAYOUT_LOWER_COL: begin
            r++;
            if (r == n) begin c++; r = c + 1; end
         end
         pmfaw_pkg::LAYOUT_UPPER_DIAG_COL: begin
            r++;
            if (r > c) begin c++; r = 0; end
         end
         default: begin
            r++;
            if (r == n) begin c++; r = c; end
         end
      endcase
      walk_row = r;
      walk_col = c;
   endtask

   // predict the tag for one accepted weight and move the walk on
   task automatic predict_tag(input logic signed [pmfaw_pkg::WEIGHT_W-1:0] weight);
      int unsigned  n;
      int unsigned  total;
      cell_tag_type tag;
      n     = clamped_nodes();
      total = cells_in_matrix(n);
      // unknown layouts and empty triangles swallow the weight
      if (total == 0) begin
         weights_dropped++;
         return;
      end
      tag.weight = weight;
      tag.row    = walk_row[pmfaw_pkg::INDEX_OUT_W-1:0];
      tag.col    = walk_col[pmfaw_pkg::INDEX_OUT_W-1:0];
      tag.mirror = (cfg_layout != pmfaw_pkg::LAYOUT_FULL);
      tag.last   = (cells_filled + 1 >= total);
      expected_tags.insert(expected_tags.size(), tag);
      if (tag.last) begin
         matrices_closed++;
         restart_walk();
      end else begin
         cells_filled++;
         advance_walk(n);
      end
   endtask

   // one line per mismatch
   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch: %s on tag %0d, got %0h, want %0h",
               field, tags_checked, got, want);
      fail_count++;
   endtask

   // compare one delivered tag with the oldest prediction
   task automatic compare_tag();
      cell_tag_type want;
      if (expected_tags.size() == 0) begin
         report_mismatch("unexpected tag", rsp_weight_out, '0);
         return;
      end
      want = expected_tags.pop_front();
      if (rsp_weight_out !== want.weight)
         report_mismatch("weight_out", rsp_weight_out, want.weight);
      if (rsp_row_index !== want.row)
         report_mismatch("row_index", 32'(rsp_row_index), 32'(want.row));
      if (rsp_col_index !== want.col)
         report_mismatch("col_index", 32'(rsp_col_index), 32'(want.col));
      if (rsp_mirror_write !== want.mirror)
         report_mismatch("mirror_write", 32'(rsp_mirror_write), 32'(want.mirror));
      if (rsp_last_entry !== want.last)
         report_mismatch("last_entry", 32'(rsp_last_entry), 32'(want.last));
      tags_checked++;
   endtask

   // tags leave before new weights enter, since every result is registered
   always @(posedge clock) begin
      if (reset) begin
         cfg_layout      = pmfaw_pkg::LAYOUT_FULL;
         cfg_nodes       = NODES_W'(1);
         fail_count      = 0;
         tags_checked    = 0;
         matrices_closed = 0;
         weights_dropped = 0;
         restart_walk();
         expected_tags.delete();
      end else begin
         if (rsp_valid && !rsp_stall) compare_tag();
         if (csr_write_enable) begin
            if (csr_index == pmfaw_pkg::CSR_LAYOUT) begin
               cfg_layout = csr_write_data[pmfaw_pkg::LAYOUT_W-1:0];
               restart_walk();
            end else if (csr_index == pmfaw_pkg::CSR_NODE_COUNT) begin
               cfg_nodes = csr_write_data[NODES_W-1:0];
               restart_walk();
            end
         end
         if (req_valid && !req_stall) predict_tag(req_weight);
      end
      tags_pending <= expected_tags.size();
   end

endmodule

@@ dv/packed_matrix_fill_address_walker_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_matrix_fill_address_walker_core_tb
// Streams edge weights through all nine packed layouts, unknown layout codes
// and clamped dimensions, with random gaps and stalls on both channels; the
// tag checker predicts every row and column and this top gives the verdict.
// ----------------------------------------------------------------------------
module packed_matrix_fill_address_walker_core_tb;

   localparam int ITEM_TARGET  = 1050;
   localparam int DRAIN_CYCLES = 4;
   localparam int LONG_HOLD    = 50;
   localparam int RUN_LIMIT_NS = 1_000_000;

   localparam int unsigned LAY_W   = pmfaw_pkg::LAYOUT_W;
   localparam int unsigned NODES_W = pmfaw_pkg::NODE_COUNT_W;
   localparam int unsigned DATA_W  = pmfaw_pkg::CSR_DATA_W;
   localparam int unsigned INDEX_W = pmfaw_pkg::CSR_INDEX_W;

   // highest code, outside the defined layouts
   localparam logic [LAY_W-1:0] UNKNOWN_LAYOUT = 4'hf;

   logic                                  clock;
   logic                                  reset            = 1'b1;
   logic                                  req_valid        = 1'b0;
   logic                                  req_stall;
   logic signed [pmfaw_pkg::WEIGHT_W-1:0] req_weight       = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall        = 1'b0;
   logic signed [pmfaw_pkg::WEIGHT_W-1:0] rsp_weight_out;
   logic [pmfaw_pkg::INDEX_OUT_W-1:0]     rsp_row_index;
   logic [pmfaw_pkg::INDEX_OUT_W-1:0]     rsp_col_index;
   logic                                  rsp_mirror_write;
   logic                                  rsp_last_entry;
   logic                                  csr_write_enable = 1'b0;
   logic [INDEX_W-1:0]                    csr_index        = '0;
   logic [DATA_W-1:0]                     csr_write_data   = '0;

   int fail_count;
   int tags_pending;
   int tags_checked;
   int matrices_closed;
   int weights_dropped;

   bit sender_gaps     = 1'b0;
   bit receiver_stalls = 1'b0;
   bit hold_requested  = 1'b0;
   int weights_sent    = 0;
   int tagged_target   = 0;
   int phase_count     = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   packed_matrix_fill_address_walker_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_weight       (req_weight),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_weight_out   (rsp_weight_out),
      .rsp_row_index    (rsp_row_index),
      .rsp_col_index    (rsp_col_index),
      .rsp_mirror_write (rsp_mirror_write),
      .rsp_last_entry   (rsp_last_entry),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   pmfaw_tag_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_weight       (req_weight),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_weight_out   (rsp_weight_out),
      .rsp_row_index    (rsp_row_index),
      .rsp_col_index    (rsp_col_index),
      .rsp_mirror_write (rsp_mirror_write),
      .rsp_last_entry   (rsp_last_entry),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .tags_pending     (tags_pending),
      .tags_checked     (tags_checked),
      .matrices_closed  (matrices_closed),
      .weights_dropped  (weights_dropped)
   );

   // watchdog
   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout with %0d tags outstanding", tags_pending);
      $display("RESULT: ERROR");
      $finish;
   end

   // tag receiver: random stalls, plus one long hold-off when requested
   initial begin : tag_receiver
      int hold;
      forever begin
         if (hold_requested) begin
            hold_requested = 1'b0;
            hold = LONG_HOLD;
         end else if (receiver_stalls) begin
            hold = $urandom_range(0, 4);
         end else begin
            hold = 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // cells stored for a layout and dimension, used only to shape the stimulus
   function automatic int cells_for(input logic [LAY_W-1:0] layout,
                                    input logic [NODES_W-1:0] nodes);
      int n;
      if (nodes == '0)
         n = 1;
      else if (nodes > pmfaw_pkg::MAX_NODES_DEFAULT)
         n = int'(pmfaw_pkg::MAX_NODES_DEFAULT);
      else
         n = int'(nodes);
      if (layout > pmfaw_pkg::LAYOUT_LOWER_DIAG_COL) return 0;
      if (layout == pmfaw_pkg::LAYOUT_FULL) return n * n;
      if (layout == pmfaw_pkg::LAYOUT_UPPER_ROW || layout == pmfaw_pkg::LAYOUT_LOWER_ROW ||
          layout == pmfaw_pkg::LAYOUT_UPPER_COL || layout == pmfaw_pkg::LAYOUT_LOWER_COL)
         return (n * n - n) / 2;
      return (n * n + n) / 2;
   endfunction

   // mostly random weights, with the sign and range extremes mixed in
   function automatic logic signed [pmfaw_pkg::WEIGHT_W-1:0] pick_weight(input int sel);
      case (sel)
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // one weight transfer, after a random gap when gaps are on
   task automatic send_weight(input logic signed [pmfaw_pkg::WEIGHT_W-1:0] weight);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_weight <= weight;
      do @(posedge clock); while (req_stall);
      weights_sent++;
   endtask

   // register write, with the enable dropped again before the task returns
   task automatic write_reg(input logic [INDEX_W-1:0] index,
                            input logic [DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every predicted tag has arrived and the pipe is empty
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tags_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // layout write keeps random upper data bits, which the block must ignore
   task automatic configure(input logic [LAY_W-1:0] layout,
                            input logic [NODES_W-1:0] nodes);
      logic [DATA_W-1:0] layout_word;
      layout_word = DATA_W'($urandom);
      layout_word[LAY_W-1:0] = layout;
      write_reg(pmfaw_pkg::CSR_LAYOUT, layout_word);
      write_reg(pmfaw_pkg::CSR_NODE_COUNT, nodes);
      phase_count++;
   endtask

   // one directed phase with edge-case weights
   task automatic directed_phase(input logic [LAY_W-1:0] layout,
                                 input logic [NODES_W-1:0] nodes,
                                 input int count);
      configure(layout, nodes);
      for (int i = 0; i < count; i++) send_weight(pick_weight(i % 4));
      drain();
   endtask

   // stimulus
   initial begin : stimulus
      logic [LAY_W-1:0]   layout;
      logic [NODES_W-1:0] nodes;
      logic [INDEX_W-1:0] spare_index;
      int                 total;
      int                 count;
      int                 split;
      int                 sel;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset state: full layout, one node
      send_weight(pick_weight(3));
      drain();

      // every layout over a two-node matrix, one full pass each
      for (int l = 0; l <= int'(pmfaw_pkg::LAYOUT_LOWER_DIAG_COL); l++)
         directed_phase(LAY_W'(l), NODES_W'(2), cells_for(LAY_W'(l), NODES_W'(2)));
      // unknown layout code, empty strict triangle, zero dimension
      directed_phase(UNKNOWN_LAYOUT, NODES_W'(2), 1);
      directed_phase(pmfaw_pkg::LAYOUT_UPPER_ROW, NODES_W'(1), 1);
      directed_phase(pmfaw_pkg::LAYOUT_FULL, NODES_W'(0), 2);

      // random phases, mostly whole matrices with random content
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      while (tagged_target < ITEM_TARGET) begin
         sender_gaps     = ($urandom_range(0, 3) != 0);
         receiver_stalls = ($urandom_range(0, 3) != 0);
         sel = $urandom_range(0, 19);
         if (sel < 2)
            layout = LAY_W'($urandom_range(int'(pmfaw_pkg::LAYOUT_LOWER_DIAG_COL) + 1,
                                           (1 << LAY_W) - 1));
         else
            layout = LAY_W'($urandom_range(int'(pmfaw_pkg::LAYOUT_FULL),
                                           int'(pmfaw_pkg::LAYOUT_LOWER_DIAG_COL)));
         sel = $urandom_range(0, 19);
         case (sel)
            0:       nodes = NODES_W'(0);
            1:       nodes = NODES_W'(pmfaw_pkg::MAX_NODES_DEFAULT);
            2:       nodes = '1;
            3:       nodes = NODES_W'($urandom_range(9, 2047));
            default: nodes = NODES_W'($urandom_range(1, 8));
         endcase
         total = cells_for(layout, nodes);
         if (total == 0)
            count = $urandom_range(1, 4);
         else if (total > 64)
            count = $urandom_range(5, 40);
         else
            count = total * $urandom_range(1, 3) +
                    (($urandom_range(0, 3) == 0) ? $urandom_range(0, total - 1) : 0);

         // pressure phases: long back-to-back stream under a receiver hold-off
         if (phase_count == 13 || phase_count == 30) begin
            layout      = pmfaw_pkg::LAYOUT_FULL;
            nodes       = NODES_W'(8);
            total       = 64;
            count       = 64;
            sender_gaps = 1'b0;
            hold_requested = 1'b1;
         end

         configure(layout, nodes);
         split = ($urandom_range(0, 4) == 0 && count > 1) ? $urandom_range(1, count - 1)
                                                          : count;
         for (int i = 0; i < split; i++) send_weight(pick_weight($urandom_range(0, 11)));
         if (split < count) begin
            // a write to an unmapped index must leave the walk where it is
            drain();
            spare_index = INDEX_W'($urandom_range(int'(pmfaw_pkg::CSR_NODE_COUNT) + 1,
                                                  (1 << INDEX_W) - 1));
            write_reg(spare_index, DATA_W'($urandom));
            for (int i = split; i < count; i++)
               send_weight(pick_weight($urandom_range(0, 11)));
         end
         drain();
         if (total != 0) tagged_target += count;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d settings over all nine layouts, unknown codes and clamped sizes",
               phase_count);
      $display("%0d weights sent, %0d tags checked, %0d matrices closed, %0d dropped",
               weights_sent, tags_checked, matrices_closed, weights_dropped);
      if (fail_count == 0 && tags_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
